[rtl/assert_macros.svh]
// Assertion macros for the RTL of the tap and swipe classifier.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, clocked on clk and disabled while reset is held.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check, clocked on clk and disabled in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ttsc_pkg.sv]
// Package for the touch tap and swipe classifier: event and gesture codes,
// register indexes and field widths. No dependencies.
`timescale 1ns / 1ps

package ttsc_pkg;

    // Field widths of the stream words
    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 4;
    localparam int POS_W     = 16;
    localparam int TIME_W    = 32;
    localparam int GEST_W    = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 8;

    // Signed width of a displacement: position range plus sign plus margin
    localparam int DIFF_W = POS_W + 2;

    // Event kinds
    localparam logic [CMD_W-1:0] CMD_DOWN   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UP     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MOTION = 2'd2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TAP_THR_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_THR_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MAX   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_MAX  = 2'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] TAP_THR_X_RST = 16'd9102;
    localparam logic [CFG_W-1:0] TAP_THR_Y_RST = 16'd12136;
    localparam logic [CFG_W-1:0] TAP_MAX_RST   = 16'd500;
    localparam logic [CFG_W-1:0] DROP_MAX_RST  = 16'd200;

    // Gesture codes
    typedef enum logic [GEST_W-1:0] {
        G_ROT_RIGHT  = 3'd0,
        G_ROT_LEFT   = 3'd1,
        G_MOVE_RIGHT = 3'd2,
        G_MOVE_LEFT  = 3'd3,
        G_DROP       = 3'd4,
        G_MOVE_DOWN  = 3'd5,
        G_HOLD       = 3'd6
    } gesture_t;

endpackage

[rtl/touch_tap_swipe_classifier.sv]
// Touch tap and swipe classifier, top level: slot table and gesture decode.
// Depends on ttsc_pkg and assert_macros.svh.
`timescale 1ns / 1ps

// Usage
//   Slave stream s_*: one touch event word per handshake; s_tuser carries the
//   event kind (down, up, motion), s_tdata the slot, position and time.
//   Master stream m_*: one gesture word for each release that classifies.
//   cfg_*: write thresholds while no event is in flight; no read-back.
// Path: an accepted event sits in the input register; its gesture is loaded
//   into the output register once that can take it, and m_tvalid is high from
//   then until taken.
// Throughput: one event per cycle while the output is not stalled. The slot table
//   is read and written in the same cycle as the decode, so back-to-back events
//   on one slot see each other's update.
// Down, motion and unmatched-up events produce no output word.
// Reset clears all press flags and both stream valid flags and restores the
//   default thresholds; stored press positions and times need no clearing.
// Stall: while m_tready is low with a word waiting, the input register holds
//   one more event and s_tready drops only when both are full.
module touch_tap_swipe_classifier #(
    parameter int NUM_SLOTS  = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [ttsc_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [ttsc_pkg::CFG_W-1:0]       cfg_wdata,
    // Event stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // command[1:0]
    input  logic [ttsc_pkg::CMD_W-1:0]       s_tuser,
    // finger_slot[3:0], pos_x[19:4], pos_y[35:20], time_ms[67:36],
    // zero pad[71:68]
    input  logic [ttsc_pkg::IN_DATA_W-1:0]   s_tdata,
    // Gesture stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // gesture[2:0], gesture_slot[6:3], zero pad[7]
    output logic [ttsc_pkg::OUT_DATA_W-1:0]  m_tdata
);

    import ttsc_pkg::*;

    // Table geometry: slot field is 4 bits, so at most 16 entries are reachable
    localparam int DEPTH = (NUM_SLOTS < (1 << SLOT_W)) ? NUM_SLOTS : (1 << SLOT_W);
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
    localparam int HW    = COORD_BITS + 1;
    localparam logic [HW-1:0] COORD_HALF = HW'(1) << (COORD_BITS - 1);
    localparam int RW    = 7;

    // Configuration registers
    logic [CFG_W-1:0] tap_thr_x_reg;
    logic [CFG_W-1:0] tap_thr_y_reg;
    logic [CFG_W-1:0] tap_max_reg;
    logic [CFG_W-1:0] drop_max_reg;

    // Input register
    logic              s1_valid_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [POS_W-1:0]  s1_x_reg;
    logic [POS_W-1:0]  s1_y_reg;
    logic [TIME_W-1:0] s1_time_reg;

    // Slot table
    logic [DEPTH-1:0]  pressed_reg;
    logic [CW-1:0]     press_x_reg    [DEPTH];
    logic [CW-1:0]     press_y_reg    [DEPTH];
    logic [TIME_W-1:0] press_time_reg [DEPTH];

    // Output register
    logic                  m_valid_reg;
    logic [GEST_W-1:0]     m_gesture_reg;
    logic [SLOT_W-1:0]     m_slot_reg;

    // Decode signals
    logic                     s1_adv;
    logic                     in_range;
    logic [IW-1:0]            idx;
    logic                     held;
    logic                     do_press;
    logic                     do_release;
    logic [CW-1:0]            x_c;
    logic [CW-1:0]            y_c;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] adx;
    logic signed [DIFF_W-1:0] ady;
    logic signed [DIFF_W-1:0] tx;
    logic signed [DIFF_W-1:0] ty;
    logic [TIME_W-1:0]        duration;
    logic                     small_x;
    logic                     small_y;
    logic                     is_short;
    logic                     is_fast;
    logic                     cls_valid;
    gesture_t                 cls_gesture;

    // Handshake: input register advances when the output register can take
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_slot_reg, m_gesture_reg};

    // Look up the slot of the held event
    assign in_range   = ({3'b000, s1_slot_reg} < RW'(NUM_SLOTS));
    assign idx        = IW'(s1_slot_reg);
    assign held       = pressed_reg[idx];
    assign do_press   = s1_adv && in_range && (s1_cmd_reg == CMD_DOWN) && !held;
    assign do_release = s1_adv && in_range && (s1_cmd_reg == CMD_UP) && held;

    // Displacement, magnitude and duration
    assign x_c      = s1_x_reg[CW-1:0];
    assign y_c      = s1_y_reg[CW-1:0];
    assign dx       = $signed(DIFF_W'(x_c)) - $signed(DIFF_W'(press_x_reg[idx]));
    assign dy       = $signed(DIFF_W'(y_c)) - $signed(DIFF_W'(press_y_reg[idx]));
    assign adx      = dx[DIFF_W-1] ? -dx : dx;
    assign ady      = dy[DIFF_W-1] ? -dy : dy;
    assign tx       = $signed(DIFF_W'(tap_thr_x_reg));
    assign ty       = $signed(DIFF_W'(tap_thr_y_reg));
    assign duration = s1_time_reg - press_time_reg[idx];
    assign small_x  = adx < tx;
    assign small_y  = ady < ty;
    assign is_short = duration < TIME_W'(tap_max_reg);
    assign is_fast  = duration < TIME_W'(drop_max_reg);

    // Classify the release; borderline, diagonal or long still presses give nothing
    always_comb
    begin
        cls_valid   = 1'b1;
        cls_gesture = G_HOLD;
        if (is_short && small_x && small_y)
        begin
            cls_gesture = (HW'(x_c) > COORD_HALF) ? G_ROT_RIGHT : G_ROT_LEFT;
        end
        else if ((dx > tx) && small_y)
        begin
            cls_gesture = G_MOVE_RIGHT;
        end
        else if ((dx < -tx) && small_y)
        begin
            cls_gesture = G_MOVE_LEFT;
        end
        else if ((dy > ty) && small_x)
        begin
            cls_gesture = is_fast ? G_DROP : G_MOVE_DOWN;
        end
        else if ((dy < -ty) && small_x)
        begin
            cls_gesture = G_HOLD;
        end
        else
        begin
            cls_valid = 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_thr_x_reg <= TAP_THR_X_RST;
            tap_thr_y_reg <= TAP_THR_Y_RST;
            tap_max_reg   <= TAP_MAX_RST;
            drop_max_reg  <= DROP_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TAP_THR_X: tap_thr_x_reg <= cfg_wdata;
                REG_TAP_THR_Y: tap_thr_y_reg <= cfg_wdata;
                REG_TAP_MAX:   tap_max_reg   <= cfg_wdata;
                REG_DROP_MAX:  drop_max_reg  <= cfg_wdata;
                default:       tap_thr_x_reg <= tap_thr_x_reg;
            endcase
        end
    end

    // Control state: valid flags and press flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pressed_reg  <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_adv)
            begin
                m_valid_reg <= do_release && cls_valid;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (do_press)
            begin
                pressed_reg[idx] <= 1'b1;
            end
            else if (do_release)
            begin
                pressed_reg[idx] <= 1'b0;
            end
        end
    end

    // Payload: capture the event word, record presses, load the gesture word
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            s1_cmd_reg  <= s_tuser;
            s1_slot_reg <= s_tdata[3:0];
            s1_x_reg    <= s_tdata[19:4];
            s1_y_reg    <= s_tdata[35:20];
            s1_time_reg <= s_tdata[67:36];
        end
        if (do_press)
        begin
            press_x_reg[idx]    <= x_c;
            press_y_reg[idx]    <= y_c;
            press_time_reg[idx] <= s1_time_reg;
        end
        if (s1_adv)
        begin
            m_gesture_reg <= cls_gesture;
            m_slot_reg    <= s1_slot_reg;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_IMPL(a_ready_when_empty, !s1_valid_reg, s_tready, "empty input not ready")
    `ASSERT_IMPL(a_stall_holds, m_valid_reg && !m_tready, !s1_adv, "waiting word lost")
    `ASSERT_NEXT(a_release_frees, do_release, !pressed_reg[$past(idx)], "release kept slot")
    `ASSERT_NEXT(a_press_holds, do_press, pressed_reg[$past(idx)], "slot free after press")
    `ASSERT_NEXT(a_gesture_loaded, do_release && cls_valid, m_valid_reg, "gesture not shown")

endmodule
